>>> hdl/ose_pkg.sv
`timescale 1ns / 1ps

package ose_pkg;

  // Opcode bytes of the expanded scripts.
  localparam logic [7:0] OPC_DUP       = 8'h76;
  localparam logic [7:0] OPC_HASH160   = 8'hA9;
  localparam logic [7:0] OPC_EQ_VERIFY = 8'h88;
  localparam logic [7:0] OPC_CHECK_SIG = 8'hAC;
  localparam logic [7:0] OPC_EQ        = 8'h87;
  localparam logic [7:0] PUSH_HASH     = 8'd20;
  localparam logic [7:0] PUSH_KEY      = 8'd33;

  // Payload lengths of the fixed-length script kinds.
  localparam logic [5:0] HashLen = 6'd20;
  localparam logic [5:0] KeyLen  = 6'd32;

  // Size codes carried by a header.
  localparam logic [7:0] CODE_PKH    = 8'd0;
  localparam logic [7:0] CODE_SH     = 8'd1;
  localparam logic [7:0] CODE_KEY_E  = 8'd2;
  localparam logic [7:0] CODE_KEY_O  = 8'd3;
  localparam logic [7:0] CODE_UNC_E  = 8'd4;
  localparam logic [7:0] CODE_UNC_O  = 8'd5;

  // Input item kinds.
  localparam logic REQ_HEADER  = 1'b0;
  localparam logic REQ_PAYLOAD = 1'b1;

  // Script currently being expanded.
  typedef enum logic [2:0] {
    MODE_IDLE = 3'd0,
    MODE_PKH  = 3'd1,
    MODE_SH   = 3'd2,
    MODE_KEY  = 3'd3,
    MODE_RAW  = 3'd4
  } mode_t;

  // One result waiting for transfer.
  typedef struct packed {
    logic [7:0] dat;
    logic       eos;
    logic       nob;
    logic       uns;
  } res_t;

endpackage

>>> hdl/output_script_template_expander.sv
`timescale 1ns / 1ps

// Streaming expander for compressed output scripts.
// Input channel (in_valid/in_ready): a header item (req_type = 0) carries the
// size code that opens a script; payload items (req_type = 1) carry its bytes.
// Output channel (out_valid/out_ready): one expanded script byte per transfer,
// with end_of_script on the last result of a script; no_byte and unsupported
// flag empty scripts.
// Each accepted item is expanded in the cycle it is accepted into a small
// result buffer of up to three entries; the first result is visible in the
// cycle after the input transfer. The buffer drains one result per cycle
// while out_ready is high. Throughput: an item that gives one or no result
// is accepted every cycle while the receiver keeps out_ready high. An item
// that gives two or three results holds the input until the single output
// port has drained the buffer down to its last result.
// A new item is taken whilst the last buffered result is being transferred.
// When the receiver stalls, the buffer holds its results and in_ready drops
// once a result is pending. Reset empties the buffer and closes any open
// script; no clearing pass is needed.
module output_script_template_expander
  import ose_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       req_type,
  input  logic [7:0] size_code,
  input  logic [7:0] data_byte,
  input  logic       last,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       end_of_script,
  output logic       no_byte,
  output logic       unsupported
);

  mode_t       mode, mode_next;
  logic  [5:0] seen, seen_next, seen_inc;
  logic  [1:0] cnt;
  logic  [1:0] ld_cnt;
  res_t        q   [3];
  res_t        ld  [3];
  logic        in_fire, out_fire;

  assign out_valid = (cnt != 2'd0);
  assign in_ready  = (cnt == 2'd0) || ((cnt == 2'd1) && out_ready);
  assign in_fire   = in_valid && in_ready;
  assign out_fire  = out_valid && out_ready;
  assign seen_inc  = seen + 6'd1;

  assign out_byte      = q[0].dat;
  assign end_of_script = q[0].eos;
  assign no_byte       = q[0].nob;
  assign unsupported   = q[0].uns;

  // Expansion of the incoming item into its results and the next script state.
  always_comb begin
    mode_next = mode;
    seen_next = seen;
    ld_cnt    = 2'd0;
    for (int i = 0; i < 3; i++) begin
      ld[i] = '0;
    end
    if (req_type == REQ_HEADER) begin
      mode_next = MODE_IDLE;
      seen_next = 6'd0;
      priority if (size_code == CODE_PKH) begin
        ld[0].dat = OPC_DUP;
        ld[1].dat = OPC_HASH160;
        ld[2].dat = PUSH_HASH;
        ld_cnt    = 2'd3;
        mode_next = MODE_PKH;
      end else if (size_code == CODE_SH) begin
        ld[0].dat = OPC_HASH160;
        ld[1].dat = PUSH_HASH;
        ld_cnt    = 2'd2;
        mode_next = MODE_SH;
      end else if (size_code == CODE_KEY_E || size_code == CODE_KEY_O) begin
        ld[0].dat = PUSH_KEY;
        ld[1].dat = size_code;
        ld_cnt    = 2'd2;
        mode_next = MODE_KEY;
      end else if (size_code == CODE_UNC_E || size_code == CODE_UNC_O) begin
        ld[0].eos = 1'b1;
        ld[0].nob = 1'b1;
        ld[0].uns = 1'b1;
        ld_cnt    = 2'd1;
      end else if (last) begin
        ld[0].eos = 1'b1;
        ld[0].nob = 1'b1;
        ld_cnt    = 2'd1;
      end else begin
        mode_next = MODE_RAW;
      end
    end else begin
      ld[0].dat = data_byte;
      unique case (mode)
        MODE_PKH, MODE_SH: begin
          if (seen_inc >= HashLen) begin
            mode_next = MODE_IDLE;
            seen_next = 6'd0;
            if (mode == MODE_PKH) begin
              ld[1].dat = OPC_EQ_VERIFY;
              ld[2].dat = OPC_CHECK_SIG;
              ld[2].eos = 1'b1;
              ld_cnt    = 2'd3;
            end else begin
              ld[1].dat = OPC_EQ;
              ld[1].eos = 1'b1;
              ld_cnt    = 2'd2;
            end
          end else begin
            seen_next = seen_inc;
            ld_cnt    = 2'd1;
          end
        end
        MODE_KEY: begin
          if (seen_inc >= KeyLen) begin
            mode_next = MODE_IDLE;
            seen_next = 6'd0;
            ld[1].dat = OPC_CHECK_SIG;
            ld[1].eos = 1'b1;
            ld_cnt    = 2'd2;
          end else begin
            seen_next = seen_inc;
            ld_cnt    = 2'd1;
          end
        end
        MODE_RAW: begin
          ld[0].eos = last;
          ld_cnt    = 2'd1;
          if (last) begin
            mode_next = MODE_IDLE;
          end
        end
        default: begin
          // Payload outside a script is dropped.
          mode_next = MODE_IDLE;
        end
      endcase
    end
  end

  // Script state and result count.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_IDLE;
      seen <= 6'd0;
      cnt  <= 2'd0;
    end else begin
      if (in_fire) begin
        mode <= mode_next;
        seen <= seen_next;
        cnt  <= ld_cnt;
      end else if (out_fire) begin
        cnt <= cnt - 2'd1;
      end
    end
  end

  // Result buffer: loaded on an input transfer, shifted on an output transfer.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      q[0] <= ld[0];
      q[1] <= ld[1];
      q[2] <= ld[2];
    end else if (out_fire) begin
      q[0] <= q[1];
      q[1] <= q[2];
    end
  end

endmodule

>>> hdl/ose_checker.sv
`timescale 1ns / 1ps

module ose_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       end_of_script,
  input logic       no_byte,
  input logic       unsupported
);

  // A pending result stays offered until its transfer.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_byte)
      && $stable(end_of_script))
    else $error("result dropped or changed while stalled");

  // An empty script result closes the script and carries a zero byte.
  a_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid && no_byte |-> end_of_script && (out_byte == 8'd0))
    else $error("empty script result malformed");

  // Unsupported codes always give an empty script.
  a_uns: assert property (@(posedge clk) disable iff (rst)
    out_valid && unsupported |-> no_byte)
    else $error("unsupported result carries a byte");

  // With nothing pending the block takes input.
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with an empty result buffer");

endmodule

bind output_script_template_expander ose_checker u_ose_checker (
  .clk           (clk),
  .rst           (rst),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_byte      (out_byte),
  .end_of_script (end_of_script),
  .no_byte       (no_byte),
  .unsupported   (unsupported)
);
